// ===== rtl/vector_turn_toward_heading_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef VECTOR_TURN_TOWARD_HEADING_MACROS_SVH
`define VECTOR_TURN_TOWARD_HEADING_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define VTTH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VTTH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vtth_pkg.sv =====
`timescale 1ns / 1ps
package vtth_pkg;

    // Pre-scale of components entering the CORDIC.
    localparam int GUARD_BITS = 2;
    // Extra headroom bits for CORDIC growth.
    localparam int GROW_BITS = 4;
    // 1/K of the infinite CORDIC product, Q31.
    localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

    // atan(2^-i) in 32-bit binary angle units.
    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/vtth_vectoring.sv =====
`timescale 1ns / 1ps
module vtth_vectoring import vtth_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16,
    parameter int CORDIC_STAGES  = 16,
    localparam int W = COMPONENT_BITS + GUARD_BITS + GROW_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_x,
    input  logic signed [COMPONENT_BITS-1:0] i_y,
    input  logic        [ANGLE_BITS-1:0]     i_target,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [W-1:0]              o_x,
    output logic signed [W-1:0]              o_y,
    output logic        [ANGLE_BITS-1:0]     o_target,
    output logic        [31:0]               o_phi
);
    localparam int NS = CORDIC_STAGES;

    logic                    r_v   [0:NS];
    logic signed [W-1:0]     r_vx  [0:NS];
    logic signed [W-1:0]     r_vy  [0:NS];
    logic        [31:0]      r_phi [0:NS];
    logic signed [W-1:0]     r_ox  [0:NS];
    logic signed [W-1:0]     r_oy  [0:NS];
    logic [ANGLE_BITS-1:0]   r_tg  [0:NS];
    logic                    w_rdy [0:NS+1];
    logic signed [W-1:0]     w_gx, w_gy;

    // Bubble-collapsing ready chain
    assign w_rdy[NS+1] = i_ready;
    for (genvar k = 0; k <= NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[0];

    // Guard-scaled input components
    assign w_gx = W'(i_x) <<< GUARD_BITS;
    assign w_gy = W'(i_y) <<< GUARD_BITS;

    // Entry stage: fold left half plane onto the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_ox[0] <= w_gx;
            r_oy[0] <= w_gy;
            r_tg[0] <= i_target;
            if (w_gx < 0) begin
                r_vx[0]  <= -w_gx;
                r_vy[0]  <= -w_gy;
                r_phi[0] <= 32'h8000_0000;
            end else begin
                r_vx[0]  <= w_gx;
                r_vy[0]  <= w_gy;
                r_phi[0] <= 32'd0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero
    for (genvar k = 1; k <= NS; k++) begin : g_st
        logic signed [W-1:0] w_tx, w_ty;
        logic        [31:0]  w_at;
        assign w_tx = r_vx[k-1] >>> (k-1);
        assign w_ty = r_vy[k-1] >>> (k-1);
        assign w_at = f_atan(5'(k-1));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_ox[k] <= r_ox[k-1];
                r_oy[k] <= r_oy[k-1];
                r_tg[k] <= r_tg[k-1];
                if (r_vy[k-1] >= 0) begin
                    r_vx[k]  <= r_vx[k-1] + w_ty;
                    r_vy[k]  <= r_vy[k-1] - w_tx;
                    r_phi[k] <= r_phi[k-1] + w_at;
                end else begin
                    r_vx[k]  <= r_vx[k-1] - w_ty;
                    r_vy[k]  <= r_vy[k-1] + w_tx;
                    r_phi[k] <= r_phi[k-1] - w_at;
                end
            end
        end
    end

    assign o_valid  = r_v[NS];
    assign o_x      = r_ox[NS];
    assign o_y      = r_oy[NS];
    assign o_target = r_tg[NS];
    assign o_phi    = r_phi[NS];

endmodule

// ===== rtl/vtth_steer.sv =====
`timescale 1ns / 1ps
module vtth_steer import vtth_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16,
    localparam int W = COMPONENT_BITS + GUARD_BITS + GROW_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [15:0]                  i_max_step,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [W-1:0]          i_x,
    input  logic signed [W-1:0]          i_y,
    input  logic [ANGLE_BITS-1:0]        i_target,
    input  logic [31:0]                  i_phi,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [W-1:0]          o_x,
    output logic signed [W-1:0]          o_y,
    output logic signed [33:0]           o_z
);
    localparam int AB = ANGLE_BITS;
    localparam int CW = (AB + 2 > 17) ? AB + 2 : 17;
    localparam logic [32:0] RND = (AB < 32) ? (33'd1 << (31 - AB)) : 33'd0;
    localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

    logic                 r_v1, r_v2;
    logic signed [W-1:0]  r_x1, r_y1, r_x2, r_y2;
    logic signed [AB:0]   r_sd;
    logic        [AB:0]   r_abs;
    logic signed [33:0]   r_z2;
    logic                 w_rdy1, w_rdy2;
    logic [32:0]          w_sum;
    logic [AB-1:0]        w_head, w_d;
    logic signed [AB:0]   w_sd, w_ms, w_delta;
    logic signed [33:0]   w_d32;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: round heading, wrapped signed difference and its magnitude
    assign w_sum  = {1'b0, i_phi} + RND;
    assign w_head = w_sum[31 -: AB];
    assign w_d    = i_target - w_head;
    assign w_sd   = (w_d > HALF) ? $signed({1'b1, w_d}) : $signed({1'b0, w_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_x1  <= i_x;
            r_y1  <= i_y;
            r_sd  <= w_sd;
            r_abs <= w_sd[AB] ? (AB+1)'(-w_sd) : (AB+1)'(w_sd);
        end
    end

    // Stage 2: clamp to the step, fold turns beyond a quarter
    assign w_ms    = $signed((AB+1)'(i_max_step));
    assign w_delta = (CW'(r_abs) <= CW'(i_max_step)) ? r_sd :
                     (r_sd[AB] ? -w_ms : w_ms);
    assign w_d32   = 34'(w_delta) <<< (32 - AB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            if (w_d32 > 34'sd1073741824) begin
                r_x2 <= -r_x1;
                r_y2 <= -r_y1;
                r_z2 <= w_d32 - 34'sd2147483648;
            end else if (w_d32 < -34'sd1073741824) begin
                r_x2 <= -r_x1;
                r_y2 <= -r_y1;
                r_z2 <= w_d32 + 34'sd2147483648;
            end else begin
                r_x2 <= r_x1;
                r_y2 <= r_y1;
                r_z2 <= w_d32;
            end
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x2;
    assign o_y     = r_y2;
    assign o_z     = r_z2;

endmodule

// ===== rtl/vtth_rotation.sv =====
`timescale 1ns / 1ps
module vtth_rotation import vtth_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STAGES  = 16,
    localparam int W = COMPONENT_BITS + GUARD_BITS + GROW_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [33:0]   i_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y
);
    localparam int NS = CORDIC_STAGES;

    logic                r_v  [0:NS];
    logic signed [W-1:0] r_x  [0:NS];
    logic signed [W-1:0] r_y  [0:NS];
    logic signed [33:0]  r_z  [0:NS];
    logic                w_rdy[1:NS+1];

    // Slot 0 is the incoming beat itself
    assign r_v[0] = i_valid;
    assign r_x[0] = i_x;
    assign r_y[0] = i_y;
    assign r_z[0] = i_z;

    assign w_rdy[NS+1] = i_ready;
    for (genvar k = 1; k <= NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[1];

    // One micro-rotation per stage, driving z toward zero
    for (genvar k = 1; k <= NS; k++) begin : g_st
        logic signed [W-1:0] w_tx, w_ty;
        logic signed [33:0]  w_at;
        assign w_tx = r_x[k-1] >>> (k-1);
        assign w_ty = r_y[k-1] >>> (k-1);
        assign w_at = $signed({2'b00, f_atan(5'(k-1))});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                if (r_z[k-1] >= 0) begin
                    r_x[k] <= r_x[k-1] - w_ty;
                    r_y[k] <= r_y[k-1] + w_tx;
                    r_z[k] <= r_z[k-1] - w_at;
                end else begin
                    r_x[k] <= r_x[k-1] + w_ty;
                    r_y[k] <= r_y[k-1] - w_tx;
                    r_z[k] <= r_z[k-1] + w_at;
                end
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_x     = r_x[NS];
    assign o_y     = r_y[NS];

endmodule

// ===== rtl/vtth_gain.sv =====
`timescale 1ns / 1ps
module vtth_gain import vtth_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    localparam int W = COMPONENT_BITS + GUARD_BITS + GROW_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [W-1:0]              i_x,
    input  logic signed [W-1:0]              i_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [COMPONENT_BITS-1:0] o_x,
    output logic signed [COMPONENT_BITS-1:0] o_y,
    output logic                             o_clipped
);
    localparam int CB = COMPONENT_BITS;
    localparam int PW = W + 31;
    localparam int RW = PW - 32;
    localparam logic [PW:0]   RBIAS = (PW+1)'(1) << 32;
    localparam logic [RW-1:0] POS_MAX = RW'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic [RW-1:0] NEG_MAX = RW'(64'd1 << (CB - 1));

    logic          r_v1, r_v2;
    logic [PW-1:0] r_px, r_py;
    logic          r_nx, r_ny;
    logic [CB-1:0] r_ox, r_oy;
    logic          r_clip;
    logic          w_rdy1, w_rdy2;
    logic [W-1:0]  w_mx, w_my;
    logic [CB:0]   w_sx, w_sy;

    // Round, restore sign, saturate; result is {clip, value}
    function automatic logic [CB:0] f_sat(input logic [PW-1:0] p, input logic neg);
        logic [PW:0]   s;
        logic [RW-1:0] r, nr;
        logic [CB:0]   o;
        s  = {1'b0, p} + RBIAS;
        r  = s[PW:33];
        nr = -r;
        if (neg) begin
            o = (r > NEG_MAX) ? {1'b1, 1'b1, {(CB-1){1'b0}}} : {1'b0, nr[CB-1:0]};
        end else begin
            o = (r > POS_MAX) ? {1'b1, 1'b0, {(CB-1){1'b1}}} : {1'b0, r[CB-1:0]};
        end
        return o;
    endfunction

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: magnitude times inverse gain
    assign w_mx = i_x[W-1] ? W'(-i_x) : W'(i_x);
    assign w_my = i_y[W-1] ? W'(-i_y) : W'(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_px <= PW'(w_mx) * PW'(INV_GAIN_Q31);
            r_py <= PW'(w_my) * PW'(INV_GAIN_Q31);
            r_nx <= i_x[W-1];
            r_ny <= i_y[W-1];
        end
    end

    // Stage 2: rounding and saturation into the output register
    assign w_sx = f_sat(r_px, r_nx);
    assign w_sy = f_sat(r_py, r_ny);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_ox   <= w_sx[CB-1:0];
            r_oy   <= w_sy[CB-1:0];
            r_clip <= w_sx[CB] | w_sy[CB];
        end
    end

    assign o_valid   = r_v2;
    assign o_x       = r_ox;
    assign o_y       = r_oy;
    assign o_clipped = r_clip;

endmodule

// ===== rtl/vector_turn_toward_heading.sv =====
`timescale 1ns / 1ps
// Turns a 2-D vector toward a target heading by at most max_step per beat.
// Input channel: i_valid / o_stall with i_vec_x, i_vec_y (signed) and
//   i_target_angle (binary angle, 2^ANGLE_BITS is one turn). A beat is taken
//   when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_new_x, o_new_y and o_clipped,
//   which flags saturation of either component.
// Config: i_cfg_valid / o_cfg_ready write max_step; o_cfg_ready is always
//   high. Write only while no beats are in flight.
// Pipeline: one fold stage and CORDIC_STAGES vectoring stages, two steering
//   stages, CORDIC_STAGES rotation stages, one multiply stage and one
//   round/saturate stage.
// Throughput: one beat per cycle while the receiver does not stall; every
//   stage is a register with its own valid bit.
// When the receiver stalls, the output register holds and the stages behind
//   it keep filling bubbles; o_stall rises only when every stage is full.
// Reset (synchronous, active low) empties the pipeline and clears max_step.
module vector_turn_toward_heading import vtth_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16,
    parameter int CORDIC_STAGES  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_x,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_y,
    input  logic        [ANGLE_BITS-1:0]     i_target_angle,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [COMPONENT_BITS-1:0] o_new_x,
    output logic signed [COMPONENT_BITS-1:0] o_new_y,
    output logic                             o_clipped,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic        [15:0]               i_cfg_max_step
);
`include "vector_turn_toward_heading_macros.svh"

    localparam int W = COMPONENT_BITS + GUARD_BITS + GROW_BITS;
    localparam logic [COMPONENT_BITS-1:0] POS_RAIL = {1'b0, {(COMPONENT_BITS-1){1'b1}}};
    localparam logic [COMPONENT_BITS-1:0] NEG_RAIL = {1'b1, {(COMPONENT_BITS-1){1'b0}}};

    logic [15:0]         r_max_step;
    logic                w_vec_rdy, w_vec_v, w_str_rdy, w_str_v, w_rot_rdy, w_rot_v;
    logic                w_gain_rdy;
    logic signed [W-1:0] w_vec_x, w_vec_y, w_str_x, w_str_y, w_rot_x, w_rot_y;
    logic [ANGLE_BITS-1:0] w_vec_tg;
    logic [31:0]         w_vec_phi;
    logic signed [33:0]  w_str_z;
    logic                w_on_rail;

    // Step register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_step <= i_cfg_max_step;
        end
    end

    assign o_stall = !w_vec_rdy;

    vtth_vectoring #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_vectoring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_vec_rdy),
        .i_x     (i_vec_x),
        .i_y     (i_vec_y),
        .i_target(i_target_angle),
        .o_valid (w_vec_v),
        .i_ready (w_str_rdy),
        .o_x     (w_vec_x),
        .o_y     (w_vec_y),
        .o_target(w_vec_tg),
        .o_phi   (w_vec_phi)
    );

    vtth_steer #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_steer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_step(r_max_step),
        .i_valid   (w_vec_v),
        .o_ready   (w_str_rdy),
        .i_x       (w_vec_x),
        .i_y       (w_vec_y),
        .i_target  (w_vec_tg),
        .i_phi     (w_vec_phi),
        .o_valid   (w_str_v),
        .i_ready   (w_rot_rdy),
        .o_x       (w_str_x),
        .o_y       (w_str_y),
        .o_z       (w_str_z)
    );

    vtth_rotation #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_rotation (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_str_v),
        .o_ready(w_rot_rdy),
        .i_x    (w_str_x),
        .i_y    (w_str_y),
        .i_z    (w_str_z),
        .o_valid(w_rot_v),
        .i_ready(w_gain_rdy),
        .o_x    (w_rot_x),
        .o_y    (w_rot_y)
    );

    vtth_gain #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_rot_v),
        .o_ready  (w_gain_rdy),
        .i_x      (w_rot_x),
        .i_y      (w_rot_y),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_x      (o_new_x),
        .o_y      (o_new_y),
        .o_clipped(o_clipped)
    );

    // Checks
    assign w_on_rail = o_new_x == POS_RAIL || o_new_x == NEG_RAIL ||
                       o_new_y == POS_RAIL || o_new_y == NEG_RAIL;

    `VTTH_ASSERT_NOW(a_stall_needs_full_out, o_stall, o_valid && i_stall, "stall, output free")
    `VTTH_ASSERT_NEXT(a_stall_keeps_out, o_stall, o_valid, "result lost while input stalled")
    `VTTH_ASSERT_NOW(a_clip_on_rail, o_valid && o_clipped, w_on_rail, "clip without rail value")

endmodule
